/* rtl/polyline_step_resampler_core_assert.svh */
// Assertion macros for the polyline step resampler core.
`ifndef POLYLINE_STEP_RESAMPLER_CORE_ASSERT_SVH
`define POLYLINE_STEP_RESAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PSR_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define PSR_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/psr_pkg.sv */
// Shared widths for the polyline step resampler core.
package psr_pkg;

   // Coordinate and spacing widths
   localparam int COORD_W = 32;
   localparam int STEP_W  = 31;
   // Coordinate difference, one bit wider than a coordinate
   localparam int DIFF_W  = 33;
   // Sum of squares, padded to an even width for the root
   localparam int SQ_W    = 66;
   // Integer root of the sum of squares
   localparam int ROOT_W  = 33;
   // Width of the per-segment point count
   localparam int CNT_W   = 6;

endpackage

/* rtl/polyline_step_resampler_core.sv */
// Polyline resampler: one sequencer around bit-serial add/compare steps.
// A segment vertex passes through square, root, count (cut short if it saturates), divide and
// fixup steps (divide and fixup skipped when the count is 0), then one point per cycle while the
// output is taken; a closing vertex adds its end point. A first vertex is stored, or sent alone.
// No new vertex is accepted until the previous one has issued its last point.
// Reset (synchronous, active high): no vertex held, spacing 1.0, output empty.
module polyline_step_resampler_core #(
   parameter int MAX_SEGMENT_POINTS = 63
) (
   input  logic        clock,
   input  logic        reset,
   // Input vertices
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] vertex_x, [63:32] vertex_y
   input  logic        req_tuser,   // [0] path_start
   input  logic        req_tlast,   // path_end
   // Resampled points
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] point_x, [63:32] point_y
   output logic        rsp_tlast,   // run_last
   // Spacing register
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data
);

`include "polyline_step_resampler_core_assert.svh"

   localparam logic [psr_pkg::CNT_W-1:0] MaxPts = psr_pkg::CNT_W'(MAX_SEGMENT_POINTS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SQRT,
      ST_COUNT,
      ST_DIVIDE,
      ST_FIXUP,
      ST_EMIT,
      ST_FINAL
   } state_type;

   state_type state_ff, state_in;

   logic [psr_pkg::STEP_W-1:0]  step_length_ff, step_length_in;
   logic [psr_pkg::COORD_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                        have_prev_ff, have_prev_in;
   logic [psr_pkg::COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic                        end_ff, end_in;
   logic [psr_pkg::COORD_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic                        sx_ff, sx_in, sy_ff, sy_in;
   logic [5:0]                  iter_ff, iter_in;
   logic [psr_pkg::SQ_W-1:0]    acc_ff, acc_in;
   logic [35:0]                 srem_ff, srem_in;
   logic [psr_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [psr_pkg::ROOT_W+3:0]  dv_ff, dv_in;
   logic [psr_pkg::CNT_W-1:0]   n_ff, n_in;
   logic [psr_pkg::DIFF_W-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic [psr_pkg::CNT_W:0]     rx_ff, rx_in, ry_ff, ry_in;
   logic [psr_pkg::DIFF_W-1:0]  stepq_x_ff, stepq_x_in, stepq_y_ff, stepq_y_in;
   logic [psr_pkg::CNT_W:0]     stepr_x_ff, stepr_x_in, stepr_y_ff, stepr_y_in;
   logic [psr_pkg::CNT_W-1:0]   k_ff, k_in, last_k_ff, last_k_in;
   logic                        out_valid_ff, out_valid_in;
   logic [psr_pkg::COORD_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic                        out_last_ff, out_last_in;

   // Input fields
   logic [psr_pkg::COORD_W-1:0] vx, vy;
   assign vx = req_tdata[31:0];
   assign vy = req_tdata[63:32];

   // Segment difference and magnitude
   logic [psr_pkg::DIFF_W-1:0]  dx_w, dy_w;
   logic [psr_pkg::COORD_W-1:0] adx_w, ady_w;
   assign dx_w  = {vx[31], vx} - {prev_x_ff[31], prev_x_ff};
   assign dy_w  = {vy[31], vy} - {prev_y_ff[31], prev_y_ff};
   assign adx_w = dx_w[32] ? 32'(-dx_w) : dx_w[31:0];
   assign ady_w = dy_w[32] ? 32'(-dy_w) : dy_w[31:0];

   // Square step: Horner accumulate of ax*ax + ay*ay, MSB first
   logic [psr_pkg::SQ_W-1:0] sq_sum;
   assign sq_sum = {acc_ff[64:0], 1'b0}
                 + (ax_ff[iter_ff[4:0]] ? {34'd0, ax_ff} : 66'd0)
                 + (ay_ff[iter_ff[4:0]] ? {34'd0, ay_ff} : 66'd0);

   // Root step: restoring digit-by-digit square root
   logic [35:0] rt_t, rt_trial;
   logic        rt_ge;
   assign rt_t     = {srem_ff[33:0], acc_ff[65:64]};
   assign rt_trial = {1'b0, root_ff, 2'b01};
   assign rt_ge    = rt_t >= rt_trial;

   // Count step: restoring divide of the root by the spacing
   logic                      cnt_ge;
   logic [psr_pkg::CNT_W-1:0] cnt_q;
   assign cnt_ge = {4'd0, root_ff} >= dv_ff;
   assign cnt_q  = {n_ff[4:0], cnt_ge};

   // Divide step: both lanes by the point count
   logic [psr_pkg::CNT_W:0] dvx_t, dvy_t, dvx_r, dvy_r;
   logic                    dvx_ge, dvy_ge;
   assign dvx_t  = {rx_ff[5:0], qx_ff[31]};
   assign dvy_t  = {ry_ff[5:0], qy_ff[31]};
   assign dvx_ge = dvx_t >= {1'b0, n_ff};
   assign dvy_ge = dvy_t >= {1'b0, n_ff};
   assign dvx_r  = dvx_ge ? dvx_t - {1'b0, n_ff} : dvx_t;
   assign dvy_r  = dvy_ge ? dvy_t - {1'b0, n_ff} : dvy_t;

   // Fixup: turn magnitude quotient into floor quotient for negative differences
   logic                      fxn_x, fxn_y;
   logic [psr_pkg::CNT_W-1:0] fxr_x, fxr_y;
   assign fxn_x = sx_ff && (rx_ff != '0);
   assign fxn_y = sy_ff && (ry_ff != '0);
   assign fxr_x = fxn_x ? n_ff - rx_ff[5:0] : rx_ff[5:0];
   assign fxr_y = fxn_y ? n_ff - ry_ff[5:0] : ry_ff[5:0];

   // Emit step: advance quotient and remainder by one point
   logic [psr_pkg::CNT_W+1:0] em_sx, em_sy, em_twon;
   logic                      em_wx, em_wy;
   assign em_twon = {1'b0, n_ff, 1'b0};
   assign em_sx   = {1'b0, rx_ff} + {1'b0, stepr_x_ff};
   assign em_sy   = {1'b0, ry_ff} + {1'b0, stepr_y_ff};
   assign em_wx   = em_sx >= em_twon;
   assign em_wy   = em_sy >= em_twon;

   logic out_free;
   assign out_free = !out_valid_ff || rsp_tready;

   // Sequencer next state
   always_comb begin
      state_in       = state_ff;
      step_length_in = step_length_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      have_prev_in   = have_prev_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      end_in         = end_ff;
      ax_in          = ax_ff;
      ay_in          = ay_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      iter_in        = iter_ff;
      acc_in         = acc_ff;
      srem_in        = srem_ff;
      root_in        = root_ff;
      dv_in          = dv_ff;
      n_in           = n_ff;
      qx_in          = qx_ff;
      qy_in          = qy_ff;
      rx_in          = rx_ff;
      ry_in          = ry_ff;
      stepq_x_in     = stepq_x_ff;
      stepq_y_in     = stepq_y_ff;
      stepr_x_in     = stepr_x_ff;
      stepr_y_in     = stepr_y_ff;
      k_in           = k_ff;
      last_k_in      = last_k_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_x_in       = out_x_ff;
      out_y_in       = out_y_ff;
      out_last_in    = out_last_ff;

      if (csr_wr_en) begin
         step_length_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cur_x_in = vx;
               cur_y_in = vy;
               end_in   = req_tlast;
               if (req_tuser || !have_prev_ff) begin
                  if (req_tlast) begin
                     state_in = ST_FINAL;
                  end else begin
                     prev_x_in    = vx;
                     prev_y_in    = vy;
                     have_prev_in = 1'b1;
                  end
               end else begin
                  ax_in    = adx_w;
                  ay_in    = ady_w;
                  sx_in    = dx_w[32];
                  sy_in    = dy_w[32];
                  acc_in   = '0;
                  iter_in  = 6'd31;
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            acc_in  = sq_sum;
            iter_in = iter_ff - 6'd1;
            if (iter_ff == 6'd0) begin
               iter_in  = 6'd32;
               srem_in  = '0;
               root_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            acc_in  = {acc_ff[63:0], 2'b00};
            srem_in = rt_ge ? rt_t - rt_trial : rt_t;
            root_in = {root_ff[31:0], rt_ge};
            iter_in = iter_ff - 6'd1;
            if (iter_ff == 6'd0) begin
               iter_in  = 6'd6;
               dv_in    = {step_length_ff, 6'd0};
               n_in     = '0;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            dv_in   = dv_ff >> 1;
            iter_in = iter_ff - 6'd1;
            if (iter_ff == 6'd6) begin
               // quotient of 64 or more saturates at once
               if (cnt_ge) begin
                  n_in     = MaxPts;
                  qx_in    = {1'b0, ax_ff};
                  qy_in    = {1'b0, ay_ff};
                  rx_in    = '0;
                  ry_in    = '0;
                  iter_in  = 6'd31;
                  state_in = ST_DIVIDE;
               end
            end else begin
               root_in = cnt_ge ? root_ff - dv_ff[32:0] : root_ff;
               n_in    = cnt_q;
               if (iter_ff == 6'd0) begin
                  n_in = (cnt_q > MaxPts) ? MaxPts : cnt_q;
                  if (cnt_q == '0) begin
                     // short segment: start point only
                     qx_in     = '0;
                     qy_in     = '0;
                     rx_in     = '0;
                     ry_in     = '0;
                     k_in      = '0;
                     last_k_in = '0;
                     state_in  = ST_EMIT;
                  end else begin
                     qx_in    = {1'b0, ax_ff};
                     qy_in    = {1'b0, ay_ff};
                     rx_in    = '0;
                     ry_in    = '0;
                     iter_in  = 6'd31;
                     state_in = ST_DIVIDE;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            rx_in   = {1'b0, dvx_r[5:0]};
            ry_in   = {1'b0, dvy_r[5:0]};
            qx_in   = {1'b0, qx_ff[30:0], dvx_ge};
            qy_in   = {1'b0, qy_ff[30:0], dvy_ge};
            iter_in = iter_ff - 6'd1;
            if (iter_ff == 6'd0) begin
               state_in = ST_FIXUP;
            end
         end
         ST_FIXUP: begin
            stepq_x_in = !sx_ff ? qx_ff : (fxn_x ? ~qx_ff : -qx_ff);
            stepq_y_in = !sy_ff ? qy_ff : (fxn_y ? ~qy_ff : -qy_ff);
            stepr_x_in = {fxr_x, 1'b0};
            stepr_y_in = {fxr_y, 1'b0};
            // point 0: quotient 0, remainder n of the doubled numerator
            qx_in      = '0;
            qy_in      = '0;
            rx_in      = {1'b0, n_ff};
            ry_in      = {1'b0, n_ff};
            k_in       = '0;
            last_k_in  = n_ff - 6'd1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_x_in     = prev_x_ff + qx_ff[31:0];
               out_y_in     = prev_y_ff + qy_ff[31:0];
               out_last_in  = !end_ff && (k_ff == last_k_ff);
               if (k_ff == last_k_ff) begin
                  if (end_ff) begin
                     state_in = ST_FINAL;
                  end else begin
                     prev_x_in    = cur_x_ff;
                     prev_y_in    = cur_y_ff;
                     have_prev_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end else begin
                  k_in  = k_ff + 6'd1;
                  rx_in = em_wx ? 7'(em_sx - em_twon) : em_sx[6:0];
                  ry_in = em_wy ? 7'(em_sy - em_twon) : em_sy[6:0];
                  qx_in = qx_ff + stepq_x_ff + {32'd0, em_wx};
                  qy_in = qy_ff + stepq_y_ff + {32'd0, em_wy};
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_x_in     = cur_x_ff;
               out_y_in     = cur_y_ff;
               out_last_in  = 1'b1;
               prev_x_in    = cur_x_ff;
               prev_y_in    = cur_y_ff;
               have_prev_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, datapath and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_length_ff <= 31'd65536;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         have_prev_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_length_ff <= step_length_in;
         prev_x_ff      <= prev_x_in;
         prev_y_ff      <= prev_y_in;
         have_prev_ff   <= have_prev_in;
         out_valid_ff   <= out_valid_in;
      end
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      end_ff      <= end_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      iter_ff     <= iter_in;
      acc_ff      <= acc_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      dv_ff       <= dv_in;
      n_ff        <= n_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      stepq_x_ff  <= stepq_x_in;
      stepq_y_ff  <= stepq_y_in;
      stepr_x_ff  <= stepr_x_in;
      stepr_y_ff  <= stepr_y_in;
      k_ff        <= k_in;
      last_k_ff   <= last_k_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

   // Ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_y_ff, out_x_ff};
   assign rsp_tlast  = out_last_ff;

   // Remainders stay below 2n whenever a count is in use
   logic rem_ok;
   assign rem_ok = (n_ff == '0) || ((rx_ff < {n_ff, 1'b0}) && (ry_ff < {n_ff, 1'b0}));

   // Checks
   `PSR_ASSERT_NOW(a_k_in_range, state_ff == ST_EMIT, k_ff <= last_k_ff, "point index past count")
   `PSR_ASSERT_NOW(a_n_clamped, state_ff == ST_EMIT, n_ff <= MaxPts, "point count above limit")
   `PSR_ASSERT_NOW(a_rem_bound, state_ff == ST_EMIT, rem_ok, "remainder out of range")

endmodule

/* test/polyline_step_resampler_checker.sv */
// Checker for the polyline step resampler: predicts resampled points and compares them.
module polyline_step_resampler_checker
   import psr_pkg::*;
#(
   parameter int MAX_SEGMENT_POINTS = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [2*COORD_W-1:0]  req_tdata,   // [31:0] vertex_x, [63:32] vertex_y
   input  logic                  req_tuser,   // [0] path_start
   input  logic                  req_tlast,   // path_end
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [2*COORD_W-1:0]  rsp_tdata,   // [31:0] point_x, [63:32] point_y
   input  logic                  rsp_tlast,   // run_last
   input  logic                  csr_wr_en,
   input  logic [STEP_W-1:0]     csr_wr_data,
   output int                    mismatch_count,
   output int                    points_pending
);

   localparam logic [STEP_W-1:0] SPACING_RESET = 31'd65536;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic                      last;
   } point_type;

   point_type                 expected_points[$];
   logic [STEP_W-1:0]         spacing;
   logic signed [COORD_W-1:0] held_x;
   logic signed [COORD_W-1:0] held_y;
   logic                      held_valid;

   initial begin
      mismatch_count = 0;
      points_pending = 0;
   end

   task automatic report_mismatch(string msg);
      $display("MISMATCH at cycle edge %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Largest k up to MAX_SEGMENT_POINTS with (k * spacing)^2 <= dx^2 + dy^2, exact, or 0
   function automatic int segment_points(longint dx, longint dy, logic [STEP_W-1:0] step);
      logic [79:0] ax;
      logic [79:0] ay;
      logic [79:0] dist_sq;
      logic [79:0] run;
      ax = (dx < 0) ? 80'(-dx) : 80'(dx);
      ay = (dy < 0) ? 80'(-dy) : 80'(dy);
      dist_sq = ax * ax + ay * ay;
      for (int k = MAX_SEGMENT_POINTS; k >= 1; k--) begin
         run = 80'(k) * 80'(step);
         if (run * run <= dist_sq) return k;
      end
      return 0;
   endfunction

   // base + d*k/n, rounded to nearest, ties toward plus infinity
   function automatic logic signed [COORD_W-1:0] interpolate(logic signed [COORD_W-1:0] base,
                                                              longint d, int k, int n);
      longint num;
      longint den;
      longint q;
      num = 2 * d * k + n;
      den = 2 * n;
      if (num >= 0) q = num / den;
      else q = -((-num + den - 1) / den);
      return COORD_W'(longint'(base) + q);
   endfunction

   function automatic void add_point(logic signed [COORD_W-1:0] x,
                                     logic signed [COORD_W-1:0] y, logic last);
      point_type p;
      p.x = x;
      p.y = y;
      p.last = last;
      expected_points = {expected_points, p};
   endfunction

   // Expected points for one accepted vertex
   task automatic predict_vertex(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                 logic is_start, logic is_end);
      longint dx;
      longint dy;
      int n;
      int pts;
      if (is_start || !held_valid) begin
         if (is_end) add_point(x, y, 1'b1);
      end else begin
         dx = longint'(x) - longint'(held_x);
         dy = longint'(y) - longint'(held_y);
         n = segment_points(dx, dy, spacing);
         pts = (n == 0) ? 1 : n;
         for (int k = 0; k < pts; k++) begin
            if (k == 0) add_point(held_x, held_y, !is_end && pts == 1);
            else add_point(interpolate(held_x, dx, k, n), interpolate(held_y, dy, k, n),
                           !is_end && k == pts - 1);
         end
         if (is_end) add_point(x, y, 1'b1);
      end
      held_x = x;
      held_y = y;
      held_valid = !is_end;
   endtask

   // Track config, predict on accepted vertices, compare accepted points
   always @(posedge clock) begin
      point_type p;
      if (reset) begin
         spacing = SPACING_RESET;
         held_x = '0;
         held_y = '0;
         held_valid = 1'b0;
         expected_points.delete();
      end else begin
         if (csr_wr_en) spacing = csr_wr_data;
         if (req_tvalid && req_tready)
            predict_vertex(req_tdata[COORD_W-1:0], req_tdata[2*COORD_W-1:COORD_W],
                           req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("unexpected point x=%h y=%h last=%b",
                                         rsp_tdata[COORD_W-1:0],
                                         rsp_tdata[2*COORD_W-1:COORD_W], rsp_tlast));
            end else begin
               p = expected_points.pop_front();
               if (rsp_tdata[COORD_W-1:0] !== p.x)
                  report_mismatch($sformatf("point_x got %h want %h",
                                            rsp_tdata[COORD_W-1:0], p.x));
               if (rsp_tdata[2*COORD_W-1:COORD_W] !== p.y)
                  report_mismatch($sformatf("point_y got %h want %h",
                                            rsp_tdata[2*COORD_W-1:COORD_W], p.y));
               if (rsp_tlast !== p.last)
                  report_mismatch($sformatf("run_last got %b want %b", rsp_tlast, p.last));
            end
         end
      end
      points_pending = expected_points.size();
   end

endmodule

/* test/polyline_step_resampler_core_test.sv */
// Testbench top for the polyline step resampler: stimulus, config phases and verdict.
module polyline_step_resampler_core_test;
   import psr_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int IDLE_PCT     = 30;
   localparam int DRAIN_CYCLES = 150;
   localparam logic [STEP_W-1:0] STEP_ONE  = 31'd65536;
   localparam logic [STEP_W-1:0] STEP_MAX  = '1;
   localparam logic [STEP_W-1:0] STEP_MIN  = 31'd1;
   localparam logic [STEP_W-1:0] STEP_ZERO = '0;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [2*COORD_W-1:0] req_tdata;   // [31:0] vertex_x, [63:32] vertex_y
   logic                 req_tuser;   // [0] path_start
   logic                 req_tlast;   // path_end
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b1;
   logic [2*COORD_W-1:0] rsp_tdata;   // [31:0] point_x, [63:32] point_y
   logic                 rsp_tlast;   // run_last
   logic                 csr_wr_en;
   logic [STEP_W-1:0]    csr_wr_data;

   int                   mismatch_count;
   int                   points_pending;
   int                   cycle_count = 0;
   bit                   idle_on = 1'b1;
   logic [STEP_W-1:0]    spacing_now = STEP_ONE;
   logic [COORD_W-1:0]   last_x = '0;
   logic [COORD_W-1:0]   last_y = '0;

   polyline_step_resampler_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   polyline_step_resampler_checker point_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .points_pending (points_pending)
   );

   // Clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Output back-pressure
   always @(negedge clock) begin
      rsp_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
   end

   // Offer one vertex item and wait for its acceptance; entered and left at a falling edge
   task automatic send_vertex(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, bit st, bit en);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tuser  <= st;
      req_tlast  <= en;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      last_x = x;
      last_y = y;
      @(negedge clock);
   endtask

   // Hold off the sender until every expected point has come out
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (points_pending != 0) @(negedge clock);
   endtask

   // Spacing write, only with the block idle
   task automatic set_spacing(logic [STEP_W-1:0] value);
      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      spacing_now = value;
   endtask

   // Next coordinate: mostly a few spacings from the last one, sometimes anywhere
   function automatic logic [COORD_W-1:0] next_coord(logic [COORD_W-1:0] base, int wide_pct);
      longint span;
      longint delta;
      if ($urandom_range(99) < wide_pct) return $urandom;
      span = longint'(spacing_now) * longint'($urandom_range(1, 12));
      delta = span * (longint'($urandom_range(2000)) - 1000) / 1000;
      return COORD_W'(longint'($signed(base)) + delta);
   endfunction

   // Random paths at one spacing; a few flags scrambled for broken sequences
   task automatic random_phase(logic [STEP_W-1:0] step, int count, bit quiet, int wide_pct);
      int len;
      int sent;
      bit st;
      bit en;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      set_spacing(step);
      idle_on = !quiet;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            st = (i == 0);
            en = (i == len - 1);
            if ($urandom_range(99) < 10) begin
               st = $urandom;
               en = $urandom;
            end
            if (!quiet && $urandom_range(99) < 3) drain();
            x = next_coord(last_x, wide_pct);
            y = next_coord(last_y, wide_pct);
            send_vertex(x, y, st, en);
            sent++;
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: spacing 1.0 from reset
      send_vertex(32'h0000_0000, 32'h0000_0000, 1, 0);   // first vertex, stored only
      send_vertex(32'h0064_0000, 32'h0000_0000, 0, 0);   // long segment, count saturates
      send_vertex(32'h0064_0100, 32'h0000_0000, 0, 0);   // short segment
      send_vertex(32'h0064_0100, 32'h0000_0000, 0, 0);   // zero length
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
      send_vertex(32'h8000_0000, 32'h8000_0000, 0, 1);   // extremes, closes path
      send_vertex(32'h0003_0000, 32'hFFFD_0000, 0, 0);   // new path without start flag
      send_vertex(32'h0001_0000, 32'h0001_0000, 1, 0);   // restart drops held vertex
      send_vertex(32'hFFF6_8000, 32'h0002_4000, 0, 1);   // negative dx, moderate count
      send_vertex(32'h1234_5678, 32'h8765_4321, 1, 1);   // single-vertex path

      // Zero spacing: every segment saturates
      set_spacing(STEP_ZERO);
      send_vertex(32'h0003_0000, 32'h0004_0000, 1, 0);
      send_vertex(32'h0003_0000, 32'h0004_0000, 0, 0);
      send_vertex(32'h0004_0000, 32'h0004_0000, 0, 1);

      // Largest spacing across the whole coordinate range
      set_spacing(STEP_MAX);
      send_vertex(32'h8000_0000, 32'h8000_0000, 1, 0);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1);

      // Smallest spacing, one-LSB segments
      set_spacing(STEP_MIN);
      send_vertex(32'h0000_0000, 32'h0000_0000, 1, 0);
      send_vertex(32'h0000_0000, 32'h0000_0001, 0, 0);
      send_vertex(32'h0000_0000, 32'h0000_0001, 0, 0);
      send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 0, 1);

      // Random phases; the second runs with no idling on either side
      random_phase(STEP_ONE, 80, 1'b0, 5);
      random_phase(31'($urandom_range(1, 32'h7FFF_FFFF)), 60, 1'b1, 10);
      random_phase(31'($urandom_range(256, 4096)), 70, 1'b0, 5);
      random_phase(STEP_MAX, 40, 1'b0, 40);
      random_phase(STEP_MIN, 20, 1'b0, 10);

      // Let the last points out, then a tail for stray output
      drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
